// ===== hw/rtl/csvp_pkg.sv =====
package csvp_pkg;

   localparam logic [7:0] QUOTE_BYTE     = 8'h22;
   localparam logic [7:0] SEPARATOR_RST  = 8'd44;

   // Byte address of the separator register
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEPARATOR = 3'd0;

   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_PLAIN  = 3'd1,
      MODE_QUOTED = 3'd2,
      MODE_QSEEN  = 3'd3,
      MODE_DROP   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NEED_MORE = 2'd1,
      STATUS_ERROR     = 2'd2
   } status_type;

   typedef struct packed {
      mode_type mode;
      logic     after_sep;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       record_done;
      status_type status;
   } result_type;

endpackage

// ===== hw/rtl/csvp_step.sv =====
// Next-state and result logic for one record byte or end mark.
module csvp_step (
   input  csvp_pkg::state_type  state,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_record,
   input  logic [7:0]           separator,
   output csvp_pkg::state_type  state_next,
   output logic                 has_result,
   output csvp_pkg::result_type result
);

   logic is_q;
   logic is_s;

   assign is_q = (in_byte == csvp_pkg::QUOTE_BYTE);
   assign is_s = (in_byte == separator);

   always_comb begin
      state_next         = state;
      has_result         = 1'b0;
      result.out_byte    = 8'd0;
      result.byte_valid  = 1'b0;
      result.field_end   = 1'b0;
      result.record_done = 1'b0;
      result.status      = csvp_pkg::STATUS_OK;

      case (state.mode)
         csvp_pkg::MODE_PLAIN: begin
            if (end_of_record) begin
               has_result          = 1'b1;
               result.field_end    = 1'b1;
               result.record_done  = 1'b1;
               state_next.mode     = csvp_pkg::MODE_START;
               state_next.after_sep = 1'b0;
            end else if (is_s) begin
               has_result          = 1'b1;
               result.field_end    = 1'b1;
               state_next.mode     = csvp_pkg::MODE_START;
               state_next.after_sep = 1'b1;
            end else if (is_q) begin
               state_next.mode = csvp_pkg::MODE_DROP;
            end else begin
               has_result        = 1'b1;
               result.out_byte   = in_byte;
               result.byte_valid = 1'b1;
            end
         end
         csvp_pkg::MODE_QUOTED: begin
            if (end_of_record) begin
               // field stays open into the next record
               has_result         = 1'b1;
               result.record_done = 1'b1;
               result.status      = csvp_pkg::STATUS_NEED_MORE;
            end else if (is_q) begin
               state_next.mode = csvp_pkg::MODE_QSEEN;
            end else begin
               has_result        = 1'b1;
               result.out_byte   = in_byte;
               result.byte_valid = 1'b1;
            end
         end
         csvp_pkg::MODE_QSEEN: begin
            if (end_of_record) begin
               has_result          = 1'b1;
               result.field_end    = 1'b1;
               result.record_done  = 1'b1;
               state_next.mode     = csvp_pkg::MODE_START;
               state_next.after_sep = 1'b0;
            end else if (is_q) begin
               has_result        = 1'b1;
               result.out_byte   = csvp_pkg::QUOTE_BYTE;
               result.byte_valid = 1'b1;
               state_next.mode   = csvp_pkg::MODE_QUOTED;
            end else if (is_s) begin
               has_result          = 1'b1;
               result.field_end    = 1'b1;
               state_next.mode     = csvp_pkg::MODE_START;
               state_next.after_sep = 1'b1;
            end else begin
               state_next.mode = csvp_pkg::MODE_DROP;
            end
         end
         csvp_pkg::MODE_DROP: begin
            if (end_of_record) begin
               has_result          = 1'b1;
               result.record_done  = 1'b1;
               result.status       = csvp_pkg::STATUS_ERROR;
               state_next.mode     = csvp_pkg::MODE_START;
               state_next.after_sep = 1'b0;
            end
         end
         default: begin
            if (end_of_record) begin
               has_result          = 1'b1;
               result.field_end    = state.after_sep;
               result.record_done  = 1'b1;
               state_next.mode     = csvp_pkg::MODE_START;
               state_next.after_sep = 1'b0;
            end else if (is_q) begin
               state_next.mode     = csvp_pkg::MODE_QUOTED;
               state_next.after_sep = 1'b0;
            end else if (is_s) begin
               has_result          = 1'b1;
               result.field_end    = 1'b1;
               state_next.mode     = csvp_pkg::MODE_START;
               state_next.after_sep = 1'b1;
            end else begin
               has_result          = 1'b1;
               result.out_byte     = in_byte;
               result.byte_valid   = 1'b1;
               state_next.mode     = csvp_pkg::MODE_PLAIN;
               state_next.after_sep = 1'b0;
            end
         end
      endcase
   end

endmodule

// ===== hw/rtl/csv_record_parser_core.sv =====
// CSV record parser core.
// req_ channel: one transfer per record byte (req_in_byte), or an end-of-record
//   mark (req_end_of_record = 1, byte ignored).
// rsp_ channel: zero or one transfer per request: a field byte (byte_valid),
//   a field close (field_end), or a record close (record_done + status:
//   0 ok, 1 need more, 2 error).  Bytes that produce nothing (opening quote,
//   first of a doubled quote, dropped bytes after an error) give no transfer.
// csr_ port: APB-style, separator register at byte address 0 (reset ',').
//   Change it only while the core is idle.
// Output: each result is registered in the output register, or in the skid register while rsp_ is stalled.
// Throughput: one request per cycle while req_stall is low; the parse state is a
//   3-bit mode plus one flag updated per taken request, so each byte depends only on it.
// Stall: while rsp_stall is high the output register holds its transfer and
//   one more result is caught in a skid register; req_stall rises only when
//   that skid register is full.
// Reset (synchronous): parser back to field start, separator to ',', both
//   output registers empty.
module csv_record_parser_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_in_byte,
   input  logic                                  req_end_of_record,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_byte_valid,
   output logic                                  rsp_field_end,
   output logic                                  rsp_record_done,
   output logic [1:0]                            rsp_status,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [csvp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   logic [7:0]           separator_ff;
   logic [7:0]           separator_in;
   csvp_pkg::state_type  state_ff;
   csvp_pkg::state_type  state_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   csvp_pkg::result_type out_data_ff;
   csvp_pkg::result_type out_data_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   csvp_pkg::result_type skid_data_ff;
   csvp_pkg::result_type skid_data_in;

   csvp_pkg::state_type  step_next;
   csvp_pkg::result_type step_result;
   logic                 step_has;
   logic                 req_take;
   logic                 new_result;
   logic                 out_free;
   logic                 csr_write;
   logic                 csr_hit;

   // --- configuration ---
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr == csvp_pkg::CSR_SEPARATOR);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_hit ? {24'd0, separator_ff} : 32'd0;

   always_comb begin
      separator_in = separator_ff;
      if (csr_write && csr_hit) begin
         separator_in = csr_pwdata[7:0];
      end
   end

   // --- parse step ---
   csvp_step u_step (
      .state         (state_ff),
      .in_byte       (req_in_byte),
      .end_of_record (req_end_of_record),
      .separator     (separator_ff),
      .state_next    (step_next),
      .has_result    (step_has),
      .result        (step_result)
   );

   // Requests are refused only when the skid register already holds a result.
   assign req_stall  = skid_valid_ff;
   assign req_take   = req_valid & ~req_stall;
   assign new_result = req_take & step_has;
   assign state_in   = req_take ? step_next : state_ff;

   // --- output register with skid ---
   assign out_free = ~out_valid_ff | ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // no request taken this cycle, so just drain the skid
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_result;
            out_data_in  = step_result;
         end
      end else if (new_result) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff  <= csvp_pkg::SEPARATOR_RST;
         state_ff      <= '{mode: csvp_pkg::MODE_START, after_sep: 1'b0};
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         separator_ff  <= separator_in;
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_data_ff.out_byte;
   assign rsp_byte_valid  = out_data_ff.byte_valid;
   assign rsp_field_end   = out_data_ff.field_end;
   assign rsp_record_done = out_data_ff.record_done;
   assign rsp_status      = out_data_ff.status;

endmodule
